// ===== rtl/pue_pkg.sv =====
// Shared types, constants and table builders for the particle update engine.
package pue_pkg;

    localparam int NUM_PARTICLES_DEF = 1024;

    localparam int IDX_W     = 10;
    localparam int ELAPSED_W = 20;
    localparam int ANGLE_W   = 9;
    localparam int SPEED_W   = 6;
    localparam int LIFEMS_W  = 11;
    localparam int POS_W     = 24;
    localparam int VEL_W     = 16;
    localparam int LIFE_W    = 23;
    localparam int FULL_W    = 22;
    localparam int ALPHA_W   = 8;
    localparam int TRIG_W    = 32;
    localparam int ANGLES    = 360;

    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 72;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_EMITTER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EMITTER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_LIFE = 2'd2;

    localparam logic [FULL_W-1:0] FULL_LIFE_RESET = 22'd3000000;

    localparam logic [16:0] STEP_RECIP = 17'd68719;
    localparam logic [19:0] STEP_DIV   = 20'd1000000;

    typedef struct packed {
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic [LIFE_W-1:0]       life;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
    } particle_t;

    typedef logic signed [TRIG_W-1:0] trig_tab_t [ANGLES];

    // Unsigned quotient by shift and subtract, used only while building tables.
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], num[i]};
            if (r >= den) begin
                r = r - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Signed value scaled down by 2^30 with truncation toward zero.
    function automatic longint q30_trunc(input longint v);
        longint m;
        m = (v < 0) ? -v : v;
        m = m >> 30;
        return (v < 0) ? -m : m;
    endfunction

    function automatic trig_tab_t build_trig_tab(input bit want_sin);
        trig_tab_t tab;
        longint unsigned x;
        longint unsigned t;
        longint c;
        longint s;
        longint c2;
        longint s2;
        for (int d = 0; d < ANGLES; d++) begin
            x = udiv64(longint'(d) * 314 * (64'd1 << 30) + 36000, 64'd72000);
            t = 64'd1 << 30;
            c = 64'sd1 << 30;
            s = 0;
            for (int k = 1; k <= 17; k++) begin
                t = udiv64(t * x, 64'(k) << 30);
                if ((k & 1) != 0) begin
                    if ((k & 2) != 0) s = s - longint'(t);
                    else s = s + longint'(t);
                end else begin
                    if ((k & 2) != 0) c = c - longint'(t);
                    else c = c + longint'(t);
                end
            end
            for (int n = 0; n < 2; n++) begin
                c2 = q30_trunc(c * c - s * s);
                s2 = q30_trunc(2 * s * c);
                c = c2;
                s = s2;
            end
            tab[d] = want_sin ? TRIG_W'(s) : TRIG_W'(c);
        end
        return tab;
    endfunction

endpackage

// ===== rtl/pue_trig_rom.sv =====
// Cosine and sine table per whole degree with registered read.
module pue_trig_rom
    import pue_pkg::*;
(
    input  logic                     aclk,
    input  logic                     en,
    input  logic [ANGLE_W-1:0]       angle,
    output logic signed [TRIG_W-1:0] cos_val,
    output logic signed [TRIG_W-1:0] sin_val
);

    localparam trig_tab_t COS_TAB = build_trig_tab(1'b0);
    localparam trig_tab_t SIN_TAB = build_trig_tab(1'b1);

    logic signed [TRIG_W-1:0] cos_reg;
    logic signed [TRIG_W-1:0] sin_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg <= COS_TAB[angle];
            sin_reg <= SIN_TAB[angle];
        end
    end

    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule

// ===== rtl/pue_state_mem.sv =====
// Particle state memory with a clearing pass after reset.
module pue_state_mem
    import pue_pkg::*;
#(
    parameter int NUM_PARTICLES = NUM_PARTICLES_DEF,
    localparam int ADDR_W = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output particle_t         rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  particle_t         wr_data,
    output logic              busy
);

    particle_t         mem [NUM_PARTICLES];
    particle_t         rd_data_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              clr_busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            if (clr_addr_reg == ADDR_W'(NUM_PARTICLES - 1)) begin
                clr_busy_reg <= 1'b0;
            end else begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;

endmodule

// ===== rtl/pue_alpha_div.sv =====
// Three-stage restoring divider giving saturated alpha from life over full life.
module pue_alpha_div
    import pue_pkg::*;
(
    input  logic               aclk,
    input  logic               en,
    input  logic [LIFE_W-1:0]  life_in,
    input  logic [FULL_W-1:0]  full_life,
    output logic [ALPHA_W-1:0] alpha
);

    logic [30:0] num;
    logic [30:0] rem_a;
    logic [30:0] rem_b;
    logic [30:0] rem_c;
    logic [2:0]  qa;
    logic [2:0]  qb;
    logic [2:0]  qc;
    logic [30:0] rem1_reg;
    logic [30:0] rem2_reg;
    logic [2:0]  q1_reg;
    logic [5:0]  q2_reg;
    logic [8:0]  q3_reg;

    assign num = {life_in, 8'b0} - 31'(life_in);

    always_comb begin
        rem_a = num;
        qa = '0;
        for (int i = 0; i < 3; i++) begin
            if (rem_a >= (31'(full_life) << (8 - i))) begin
                rem_a = rem_a - (31'(full_life) << (8 - i));
                qa[2 - i] = 1'b1;
            end
        end
        rem_b = rem1_reg;
        qb = '0;
        for (int i = 0; i < 3; i++) begin
            if (rem_b >= (31'(full_life) << (5 - i))) begin
                rem_b = rem_b - (31'(full_life) << (5 - i));
                qb[2 - i] = 1'b1;
            end
        end
        rem_c = rem2_reg;
        qc = '0;
        for (int i = 0; i < 3; i++) begin
            if (rem_c >= (31'(full_life) << (2 - i))) begin
                rem_c = rem_c - (31'(full_life) << (2 - i));
                qc[2 - i] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem1_reg <= rem_a;
            q1_reg   <= qa;
            rem2_reg <= rem_b;
            q2_reg   <= {q1_reg, qb};
            q3_reg   <= {q2_reg, qc};
        end
    end

    assign alpha = q3_reg[8] ? 8'hFF : q3_reg[7:0];

endmodule

// ===== rtl/particle_update_engine_core.sv =====
// Top level of the particle update engine: pipeline, interlock and configuration.
//
// Each s_ transaction updates one stored particle and yields exactly one m_
// transaction with its new position, opacity and respawn flag, in order.
// The cfg channel writes the emitter position and the full lifetime; it is
// always ready and should only be used while no transaction is in flight.
// The datapath has eight register stages. One transaction is taken per cycle
// as long as the incoming particle index differs from those of the six updates
// still ahead of their state write-back; a repeated index waits until the
// earlier update has written the state memory. After reset the state memory
// is cleared one entry per cycle, and s_tready is low until the clearing pass
// is done. When m_tready is low and the output register is occupied, the whole
// pipeline holds, nothing is dropped or repeated, and s_tready falls.
module particle_update_engine_core
    import pue_pkg::*;
#(
    parameter int NUM_PARTICLES = NUM_PARTICLES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // particle_index, elapsed_us, rand_angle_deg, rand_speed, rand_life_ms
    input  logic [S_TDATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_index, pos_x, pos_y, alpha, zero fill
    output logic [M_TDATA_W-1:0]  m_tdata,
    // respawned
    output logic                  m_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ADDR_W = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;

    typedef struct packed {
        logic [IDX_W-1:0]     idx;
        logic [ELAPSED_W-1:0] elapsed;
        logic [ANGLE_W-1:0]   angle;
        logic [6:0]           speed;
        logic [LIFEMS_W-1:0]  life_ms;
    } s1_t;

    typedef struct packed {
        logic [IDX_W-1:0]     idx;
        logic [ELAPSED_W-1:0] elapsed;
        logic [6:0]           speed;
        logic [LIFEMS_W-1:0]  life_ms;
    } s2_t;

    typedef struct packed {
        logic [IDX_W-1:0]        idx;
        logic [ELAPSED_W-1:0]    elapsed;
        logic                    resp;
        logic [LIFE_W-1:0]       life;
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [39:0]      prod_x;
        logic signed [39:0]      prod_y;
    } s3_t;

    typedef struct packed {
        logic [IDX_W-1:0]        idx;
        logic                    resp;
        logic [LIFE_W-1:0]       life;
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic                    neg_x;
        logic                    neg_y;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
    } carry_t;

    typedef struct packed {
        carry_t               c;
        logic [ELAPSED_W-1:0] elapsed;
        logic [15:0]          mag_x;
        logic [15:0]          mag_y;
    } s4_t;

    typedef struct packed {
        carry_t      c;
        logic [35:0] m_x;
        logic [35:0] m_y;
    } s5_t;

    typedef struct packed {
        carry_t      c;
        logic [35:0] m_x;
        logic [35:0] m_y;
        logic [16:0] q_x;
        logic [16:0] q_y;
    } s6_t;

    typedef struct packed {
        carry_t             c;
        logic [35:0]        m_x;
        logic [35:0]        m_y;
        logic [16:0]        q_x;
        logic [16:0]        q_y;
        logic [36:0]        p_x;
        logic [36:0]        p_y;
        logic [ALPHA_W-1:0] alpha;
    } s7_t;

    function automatic logic [15:0] round_mag(input logic signed [39:0] p);
        logic [39:0] m;
        logic [39:0] r;
        m = p[39] ? 40'(-p) : 40'(p);
        r = m + 40'd2097152;
        return 16'(r[39:22]);
    endfunction

    function automatic logic signed [POS_W-1:0] move_sat(
        input logic signed [POS_W-1:0] base,
        input logic                    neg,
        input logic [16:0]             q,
        input logic [1:0]              corr
    );
        logic [17:0]        qt;
        logic signed [25:0] sum;
        qt = 18'(q) + 18'(corr);
        if (neg) sum = 26'(base) - $signed({8'b0, qt});
        else sum = 26'(base) + $signed({8'b0, qt});
        if (sum > 26'sd8388607) return 24'sh7FFFFF;
        if (sum < -26'sd8388608) return 24'sh800000;
        return sum[POS_W-1:0];
    endfunction

    function automatic logic [1:0] step_corr(input logic [35:0] m, input logic [36:0] p);
        logic [36:0] r;
        r = {1'b0, m} - p;
        if (r[21:0] >= 22'd2000000) return 2'd2;
        if (r[21:0] >= 22'(STEP_DIV)) return 2'd1;
        return 2'd0;
    endfunction

    logic signed [POS_W-1:0] emitter_x_reg;
    logic signed [POS_W-1:0] emitter_y_reg;
    logic [FULL_W-1:0]       full_life_reg;

    logic p1_valid_reg, p2_valid_reg, p3_valid_reg, p4_valid_reg;
    logic p5_valid_reg, p6_valid_reg, p7_valid_reg, p8_valid_reg;
    logic p1_valid_next;

    s1_t s1_reg, s1_next;
    s2_t s2_reg;
    s3_t s3_reg, s3_next;
    s4_t s4_reg, s4_next;
    s5_t s5_reg;
    s6_t s6_reg;
    s7_t s7_reg;

    logic [IDX_W-1:0]        out_idx_reg;
    logic signed [POS_W-1:0] out_posx_reg;
    logic signed [POS_W-1:0] out_posy_reg;
    logic [ALPHA_W-1:0]      out_alpha_reg;
    logic                    out_resp_reg;

    logic ce, acc, hazard, issue, clear_busy;
    logic [IDX_W-1:0] idx_half, idx_full;

    particle_t                mem_rd, mem_wr;
    logic signed [TRIG_W-1:0] cos_val, sin_val;
    logic [ALPHA_W-1:0]       alpha_div;
    logic signed [24:0]       life_diff;
    logic [11:0]              life_base;
    logic [15:0]              new_mag_x, new_mag_y;
    logic signed [POS_W-1:0]  base_x, base_y, new_pos_x, new_pos_y;
    logic [1:0]               corr_x, corr_y;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emitter_x_reg <= '0;
            emitter_y_reg <= '0;
            full_life_reg <= FULL_LIFE_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_EMITTER_X: emitter_x_reg <= cfg_data;
                CFG_EMITTER_Y: emitter_y_reg <= cfg_data;
                CFG_FULL_LIFE: full_life_reg <= cfg_data[FULL_W-1:0];
                default: ;
            endcase
        end
    end

    // Flow control.
    assign ce       = !p8_valid_reg || m_tready;
    assign issue    = p1_valid_reg && !hazard;
    assign s_tready = !clear_busy && ce && (!p1_valid_reg || !hazard);
    assign acc      = s_tvalid && s_tready;
    assign p1_valid_next = acc || (p1_valid_reg && hazard);

    always_comb begin
        idx_half = s_tdata[9:0];
        for (int k = 9; k >= 5; k--) begin
            if ((longint'(NUM_PARTICLES) << k) <= 64'd1023) begin
                if (idx_half >= IDX_W'(NUM_PARTICLES << k)) begin
                    idx_half = idx_half - IDX_W'(NUM_PARTICLES << k);
                end
            end
        end
        s1_next.idx     = idx_half;
        s1_next.elapsed = s_tdata[29:10];
        s1_next.angle   = (s_tdata[38:30] >= 9'd360) ? s_tdata[38:30] - 9'd360
                                                     : s_tdata[38:30];
        s1_next.speed   = 7'((s_tdata[44:39] >= 6'd50) ? s_tdata[44:39] - 6'd50
                                                       : s_tdata[44:39]) + 7'd50;
        s1_next.life_ms = (s_tdata[55:45] >= 11'd2000) ? s_tdata[55:45] - 11'd2000
                                                       : s_tdata[55:45];
    end

    always_comb begin
        idx_full = s1_reg.idx;
        for (int k = 4; k >= 0; k--) begin
            if ((longint'(NUM_PARTICLES) << k) <= 64'd1023) begin
                if (idx_full >= IDX_W'(NUM_PARTICLES << k)) begin
                    idx_full = idx_full - IDX_W'(NUM_PARTICLES << k);
                end
            end
        end
        hazard = (p2_valid_reg && s2_reg.idx == idx_full)
              || (p3_valid_reg && s3_reg.idx == idx_full)
              || (p4_valid_reg && s4_reg.c.idx == idx_full)
              || (p5_valid_reg && s5_reg.c.idx == idx_full)
              || (p6_valid_reg && s6_reg.c.idx == idx_full)
              || (p7_valid_reg && s7_reg.c.idx == idx_full);
    end

    pue_state_mem #(
        .NUM_PARTICLES(NUM_PARTICLES)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (ce),
        .rd_addr (ADDR_W'(idx_full)),
        .rd_data (mem_rd),
        .wr_en   (ce && p7_valid_reg),
        .wr_addr (ADDR_W'(s7_reg.c.idx)),
        .wr_data (mem_wr),
        .busy    (clear_busy)
    );

    pue_trig_rom u_trig (
        .aclk    (aclk),
        .en      (ce),
        .angle   (s1_reg.angle),
        .cos_val (cos_val),
        .sin_val (sin_val)
    );

    // Stage 2: life update, respawn decision and speed times direction.
    always_comb begin
        life_diff = $signed({2'b0, mem_rd.life}) - $signed({5'b0, s2_reg.elapsed});
        life_base = 12'(s2_reg.life_ms) + 12'd1000;
        s3_next.idx     = s2_reg.idx;
        s3_next.elapsed = s2_reg.elapsed;
        s3_next.resp    = life_diff[24] || (life_diff == 25'sd0);
        s3_next.life    = s3_next.resp ? LIFE_W'(life_base * 12'd1000 + 23'd0)
                                       : life_diff[LIFE_W-1:0];
        s3_next.vel_x   = mem_rd.vel_x;
        s3_next.vel_y   = mem_rd.vel_y;
        s3_next.pos_x   = mem_rd.pos_x;
        s3_next.pos_y   = mem_rd.pos_y;
        s3_next.prod_x  = $signed({1'b0, s2_reg.speed}) * cos_val;
        s3_next.prod_y  = $signed({1'b0, s2_reg.speed}) * sin_val;
    end

    // Stage 3: round the new velocity and pick the velocity in use.
    always_comb begin
        new_mag_x = round_mag(s3_reg.prod_x);
        new_mag_y = round_mag(s3_reg.prod_y);
        s4_next.c.idx   = s3_reg.idx;
        s4_next.c.resp  = s3_reg.resp;
        s4_next.c.life  = s3_reg.life;
        s4_next.c.pos_x = s3_reg.pos_x;
        s4_next.c.pos_y = s3_reg.pos_y;
        s4_next.elapsed = s3_reg.elapsed;
        if (s3_reg.resp) begin
            s4_next.c.neg_x = s3_reg.prod_x[39];
            s4_next.c.neg_y = s3_reg.prod_y[39];
            s4_next.c.vel_x = s3_reg.prod_x[39] ? -$signed(new_mag_x) : $signed(new_mag_x);
            s4_next.c.vel_y = s3_reg.prod_y[39] ? -$signed(new_mag_y) : $signed(new_mag_y);
            s4_next.mag_x   = new_mag_x;
            s4_next.mag_y   = new_mag_y;
        end else begin
            s4_next.c.neg_x = s3_reg.vel_x[15];
            s4_next.c.neg_y = s3_reg.vel_y[15];
            s4_next.c.vel_x = s3_reg.vel_x;
            s4_next.c.vel_y = s3_reg.vel_y;
            s4_next.mag_x   = s3_reg.vel_x[15] ? 16'(-s3_reg.vel_x) : 16'(s3_reg.vel_x);
            s4_next.mag_y   = s3_reg.vel_y[15] ? 16'(-s3_reg.vel_y) : 16'(s3_reg.vel_y);
        end
    end

    pue_alpha_div u_alpha (
        .aclk      (aclk),
        .en        (ce),
        .life_in   (s3_reg.life),
        .full_life (full_life_reg),
        .alpha     (alpha_div)
    );

    // Stage 7 correction and final position with saturation.
    always_comb begin
        corr_x    = step_corr(s7_reg.m_x, s7_reg.p_x);
        corr_y    = step_corr(s7_reg.m_y, s7_reg.p_y);
        base_x    = s7_reg.c.resp ? emitter_x_reg : s7_reg.c.pos_x;
        base_y    = s7_reg.c.resp ? emitter_y_reg : s7_reg.c.pos_y;
        new_pos_x = move_sat(base_x, s7_reg.c.neg_x, s7_reg.q_x, corr_x);
        new_pos_y = move_sat(base_y, s7_reg.c.neg_y, s7_reg.q_y, corr_y);
        mem_wr.vel_x = s7_reg.c.vel_x;
        mem_wr.vel_y = s7_reg.c.vel_y;
        mem_wr.life  = s7_reg.c.life;
        mem_wr.pos_x = new_pos_x;
        mem_wr.pos_y = new_pos_y;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
            p5_valid_reg <= 1'b0;
            p6_valid_reg <= 1'b0;
            p7_valid_reg <= 1'b0;
            p8_valid_reg <= 1'b0;
        end else if (ce) begin
            p1_valid_reg <= p1_valid_next;
            p2_valid_reg <= issue;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
            p5_valid_reg <= p4_valid_reg;
            p6_valid_reg <= p5_valid_reg;
            p7_valid_reg <= p6_valid_reg;
            p8_valid_reg <= p7_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            s1_reg <= s1_next;
        end
        if (ce) begin
            s2_reg.idx     <= idx_full;
            s2_reg.elapsed <= s1_reg.elapsed;
            s2_reg.speed   <= s1_reg.speed;
            s2_reg.life_ms <= s1_reg.life_ms;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg.c   <= s4_reg.c;
            s5_reg.m_x <= 36'(s4_reg.mag_x) * 36'(s4_reg.elapsed);
            s5_reg.m_y <= 36'(s4_reg.mag_y) * 36'(s4_reg.elapsed);
            s6_reg.c   <= s5_reg.c;
            s6_reg.m_x <= s5_reg.m_x;
            s6_reg.m_y <= s5_reg.m_y;
            s6_reg.q_x <= 17'((37'(s5_reg.m_x[35:16]) * 37'(STEP_RECIP)) >> 20);
            s6_reg.q_y <= 17'((37'(s5_reg.m_y[35:16]) * 37'(STEP_RECIP)) >> 20);
            s7_reg.c     <= s6_reg.c;
            s7_reg.m_x   <= s6_reg.m_x;
            s7_reg.m_y   <= s6_reg.m_y;
            s7_reg.q_x   <= s6_reg.q_x;
            s7_reg.q_y   <= s6_reg.q_y;
            s7_reg.p_x   <= 37'(s6_reg.q_x) * 37'(STEP_DIV);
            s7_reg.p_y   <= 37'(s6_reg.q_y) * 37'(STEP_DIV);
            s7_reg.alpha <= alpha_div;
            out_idx_reg   <= s7_reg.c.idx;
            out_posx_reg  <= new_pos_x;
            out_posy_reg  <= new_pos_y;
            out_alpha_reg <= s7_reg.alpha;
            out_resp_reg  <= s7_reg.c.resp;
        end
    end

    assign m_tvalid = p8_valid_reg;
    assign m_tdata  = {6'b0, out_alpha_reg, out_posy_reg, out_posx_reg, out_idx_reg};
    assign m_tuser  = out_resp_reg;

    a_no_shared_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (p2_valid_reg && p3_valid_reg) |-> (s2_reg.idx != s3_reg.idx))
        else $error("Two updates of the same particle are in flight.");

    a_blocked_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_busy |-> !s_tready)
        else $error("A transaction was offered acceptance during the clearing pass.");

    a_hazard_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && hazard && ce) |=> p1_valid_reg)
        else $error("A waiting transaction was lost at the interlock.");

    a_respawn_visible: assert property (@(posedge aclk) disable iff (!aresetn)
        (p8_valid_reg && out_resp_reg) |-> (out_alpha_reg != 8'd0))
        else $error("A respawned particle came out fully transparent.");

endmodule

// ===== sim/particle_update_checker.sv =====
// Checker for the particle update engine: watches all channels, predicts and compares results.
module particle_update_checker
    import pue_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  m_tuser,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE_Q30 = 64'sd1 << 30;

    typedef struct {
        logic [IDX_W-1:0]          index;
        logic signed [POS_W-1:0]   pos_x;
        logic signed [POS_W-1:0]   pos_y;
        logic [ALPHA_W-1:0]        alpha;
        logic                      respawned;
    } update_t;

    longint dir_cos [ANGLES];
    longint dir_sin [ANGLES];
    longint vel_x_mem [NUM_PARTICLES_DEF];
    longint vel_y_mem [NUM_PARTICLES_DEF];
    longint life_mem [NUM_PARTICLES_DEF];
    longint pos_x_mem [NUM_PARTICLES_DEF];
    longint pos_y_mem [NUM_PARTICLES_DEF];
    longint emit_x;
    longint emit_y;
    longint full_life;
    update_t updates_due [$];

    initial begin
        longint unsigned angle_q;
        longint unsigned term;
        longint c;
        longint s;
        longint c_next;
        longint s_next;
        for (int d = 0; d < ANGLES; d++) begin
            angle_q = (longint'(d) * 314 * (64'd1 << 30) + 36000) / 72000;
            term = 64'd1 << 30;
            c = ONE_Q30;
            s = 0;
            for (int k = 1; k <= 17; k++) begin
                term = (term * angle_q) / (longint'(k) << 30);
                case (k % 4)
                    1: s = s + longint'(term);
                    2: c = c - longint'(term);
                    3: s = s - longint'(term);
                    default: c = c + longint'(term);
                endcase
            end
            repeat (2) begin
                c_next = (c * c - s * s) / ONE_Q30;
                s_next = (2 * s * c) / ONE_Q30;
                c = c_next;
                s = s_next;
            end
            dir_cos[d] = c;
            dir_sin[d] = s;
        end
    end

    function automatic longint scaled_speed(longint speed, longint trig);
        longint p;
        longint m;
        longint r;
        p = speed * 256 * trig;
        m = (p < 0) ? -p : p;
        r = (m + ONE_Q30 / 2) / ONE_Q30;
        return (p < 0) ? -r : r;
    endfunction

    function automatic longint glide(longint pos, longint vel, longint elapsed);
        longint v;
        v = pos + (vel * elapsed) / 1000000;
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return v;
    endfunction

    function automatic update_t advance_particle(logic [S_TDATA_W-1:0] d);
        update_t u;
        int idx;
        longint elapsed;
        longint life;
        int ang;
        longint speed;
        longint alpha;
        idx = d[9:0];
        elapsed = d[29:10];
        life = life_mem[idx] - elapsed;
        u.respawned = (life <= 0);
        if (u.respawned) begin
            ang = d[38:30] % 360;
            speed = d[44:39] % 50 + 50;
            vel_x_mem[idx] = scaled_speed(speed, dir_cos[ang]);
            vel_y_mem[idx] = scaled_speed(speed, dir_sin[ang]);
            life = (longint'(d[55:45] % 2000) + 1000) * 1000;
            pos_x_mem[idx] = emit_x;
            pos_y_mem[idx] = emit_y;
        end
        life_mem[idx] = life;
        pos_x_mem[idx] = glide(pos_x_mem[idx], vel_x_mem[idx], elapsed);
        pos_y_mem[idx] = glide(pos_y_mem[idx], vel_y_mem[idx], elapsed);
        if (full_life == 0) alpha = 255;
        else alpha = (life * 255) / full_life;
        if (alpha > 255) alpha = 255;
        u.index = idx;
        u.pos_x = pos_x_mem[idx];
        u.pos_y = pos_y_mem[idx];
        u.alpha = alpha;
        return u;
    endfunction

    assign pending = updates_due.size();

    always @(posedge aclk) begin
        update_t e;
        update_t got;
        if (!aresetn) begin
            emit_x = 0;
            emit_y = 0;
            full_life = 3000000;
            for (int i = 0; i < NUM_PARTICLES_DEF; i++) begin
                vel_x_mem[i] = 0;
                vel_y_mem[i] = 0;
                life_mem[i] = 0;
                pos_x_mem[i] = 0;
                pos_y_mem[i] = 0;
            end
            updates_due.delete();
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_EMITTER_X: emit_x = longint'($signed(cfg_data));
                    CFG_EMITTER_Y: emit_y = longint'($signed(cfg_data));
                    CFG_FULL_LIFE: full_life = cfg_data[FULL_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) updates_due.push_back(advance_particle(s_tdata));
            if (m_tvalid && m_tready) begin
                got.index = m_tdata[9:0];
                got.pos_x = m_tdata[33:10];
                got.pos_y = m_tdata[57:34];
                got.alpha = m_tdata[65:58];
                got.respawned = m_tuser;
                if (updates_due.size() == 0) begin
                    $display("%0t: unexpected transaction index %0d", $time, got.index);
                    fail_count++;
                end else begin
                    e = updates_due.pop_front();
                    if (got.index !== e.index || got.pos_x !== e.pos_x
                        || got.pos_y !== e.pos_y || got.alpha !== e.alpha
                        || got.respawned !== e.respawned) begin
                        $display("%0t: mismatch expected idx %0d x %0d y %0d a %0d r %0b",
                                 $time, e.index, e.pos_x, e.pos_y, e.alpha, e.respawned);
                        $display("%0t:            actual idx %0d x %0d y %0d a %0d r %0b",
                                 $time, got.index, got.pos_x, got.pos_y, got.alpha,
                                 got.respawned);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// ===== sim/particle_update_engine_core_test.sv =====
// Testbench top for the particle update engine: stimulus, idling, watchdog and verdict.
module particle_update_engine_core_test;
    import pue_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    int                    send_idle_pct;
    int                    recv_idle_pct;
    int                    quiet_cycles;

    particle_update_engine_core u_top (.*);

    particle_update_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= 20000) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [S_TDATA_W-1:0] pack_item(int idx, int el, int ang, int sp,
                                                        int lm);
        return {lm[10:0], sp[5:0], ang[8:0], el[19:0], idx[9:0]};
    endfunction

    function automatic logic [S_TDATA_W-1:0] random_item();
        if ($urandom_range(99) < 70) begin
            return pack_item($urandom_range(7), $urandom_range(200000), $urandom_range(359),
                             $urandom_range(49), $urandom_range(1999));
        end
        return pack_item($urandom, $urandom, $urandom, $urandom, $urandom);
    endfunction

    task automatic send_item(logic [S_TDATA_W-1:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic set_regs(int ex, int ey, int fl);
        write_reg(CFG_EMITTER_X, ex[23:0]);
        write_reg(CFG_EMITTER_Y, ey[23:0]);
        write_reg(CFG_FULL_LIFE, fl[23:0]);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        int ex [6] = '{8388607, -8388608, 0, -1000, 2000000, 0};
        int ey [6] = '{-8388608, 8388607, 0, 1000, -5000000, 0};
        int fl [6] = '{1, 4194303, 0, 3000000, 500000, 1500000};
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_EMITTER_X;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        quiet_cycles = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(pack_item(0, 0, 0, 0, 0));
        send_item(pack_item(1023, 1048575, 359, 49, 1999));
        send_item(pack_item(5, 1000000, 360, 50, 2000));
        send_item(pack_item(6, 1, 511, 63, 2047));
        send_item(pack_item(7, 0, 90, 10, 500));
        send_item(pack_item(0, 0, 180, 20, 100));
        send_item(pack_item(0, 500000, 270, 30, 0));
        send_item(pack_item(0, 500000, 45, 5, 0));
        send_item(pack_item(7, 3000000 % 1048576, 1, 1, 1));
        send_item(pack_item(1023, 1, 0, 0, 0));
        send_item(pack_item(1023, 1, 0, 0, 0));
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            set_regs(ex[ph], ey[ph], fl[ph]);
            send_idle_pct = (ph % 3 == 0) ? 20 : (ph % 3 == 1) ? 69 : 0;
            recv_idle_pct = (ph % 3 == 0) ? 69 : (ph % 3 == 1) ? 20 : 0;
            send_item(pack_item(ph, 1048575, 0, 49, 0));
            send_item(pack_item(ph, 1000000, 0, 49, 0));
            for (int n = 0; n < 215; n++) send_item(random_item());
            drain();
        end

        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
